FILE: hdl/dnsrp_pkg.sv
// Shared types and constants for the DNS response parser.
`timescale 1ns / 1ps
`default_nettype none
package dnsrp_pkg;

	// Ids at or above this count have no entry in the names table.
	localparam int unsigned TABLE_ENTRIES = 4;

	localparam logic [2:0] ST_FOUND      = 3'd0;
	localparam logic [2:0] ST_SERVER_ERR = 3'd1;
	localparam logic [2:0] ST_NO_ADDR    = 3'd2;
	localparam logic [2:0] ST_TRUNCATED  = 3'd3;
	localparam logic [2:0] ST_ID_RANGE   = 3'd4;

	typedef struct packed {
		logic [15:0] query_id;
		logic [3:0]  response_code;
		logic [31:0] ip_address;
		logic [2:0]  status;
	} res_t;

endpackage
`default_nettype wire

FILE: hdl/dnsrp_walker.sv
// Per-byte parse state machine and end-of-payload status encoder.
`timescale 1ns / 1ps
`default_nettype none
module dnsrp_walker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          data_byte,
	input  wire logic                last_byte,
	output dnsrp_pkg::res_t          result
);

	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_QLEN   = 4'd1;
	localparam logic [3:0] PH_QLABEL = 4'd2;
	localparam logic [3:0] PH_QTAIL  = 4'd3;
	localparam logic [3:0] PH_AFIRST = 4'd4;
	localparam logic [3:0] PH_APTR   = 4'd5;
	localparam logic [3:0] PH_ALEN   = 4'd6;
	localparam logic [3:0] PH_ALABEL = 4'd7;
	localparam logic [3:0] PH_AFIXED = 4'd8;
	localparam logic [3:0] PH_AADDR  = 4'd9;
	localparam logic [3:0] PH_ASKIP  = 4'd10;
	localparam logic [3:0] PH_DONE   = 4'd11;

	localparam logic [3:0]  HdrLast    = 4'd11;
	localparam logic [7:0]  FixedBytes = 8'd10;
	localparam logic [7:0]  QtailBytes = 8'd4;
	localparam logic [7:0]  AddrBytes  = 8'd4;
	localparam logic [15:0] IdLimit    = 16'(dnsrp_pkg::TABLE_ENTRIES);

	logic [3:0]  phase_q, phase_n;
	logic [3:0]  pos_q, pos_n;       // header byte index, only used in header phase
	logic [7:0]  lab_q, lab_n;
	logic [7:0]  ans_q, ans_n;
	logic [15:0] id_q, id_n;
	logic [3:0]  code_q, code_n;
	logic [15:0] rtype_q, rtype_n;
	logic [15:0] rclass_q, rclass_n;
	logic [15:0] rlen_q, rlen_n;
	logic [31:0] addr_q, addr_n;
	logic        found_q, found_n;
	logic [7:0]  lab_dec;
	logic [7:0]  ans_dec;

	assign lab_dec = lab_q - 8'd1;
	assign ans_dec = ans_q - 8'd1;

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		lab_n    = lab_q;
		ans_n    = ans_q;
		id_n     = id_q;
		code_n   = code_q;
		rtype_n  = rtype_q;
		rclass_n = rclass_q;
		rlen_n   = rlen_q;
		addr_n   = addr_q;
		found_n  = found_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q == 4'd0) id_n[15:8] = data_byte;
				if (pos_q == 4'd1) id_n[7:0] = data_byte;
				if (pos_q == 4'd3) code_n = data_byte[3:0];
				if (pos_q == 4'd7) ans_n = data_byte;
				pos_n = pos_q + 4'd1;
				if (pos_q == HdrLast) phase_n = PH_QLEN;
			end
			PH_QLEN: begin
				if (data_byte == 8'd0) begin
					phase_n = PH_QTAIL;
					lab_n   = QtailBytes;
				end else begin
					phase_n = PH_QLABEL;
					lab_n   = data_byte;
				end
			end
			PH_QLABEL: begin
				lab_n = lab_dec;
				if (lab_dec == 8'd0) phase_n = PH_QLEN;
			end
			PH_QTAIL: begin
				lab_n = lab_dec;
				if (lab_dec == 8'd0) phase_n = (ans_q == 8'd0) ? PH_DONE : PH_AFIRST;
			end
			PH_AFIRST: begin
				if (data_byte[7:6] != 2'b00) begin
					phase_n = PH_APTR;
				end else if (data_byte == 8'd0) begin
					phase_n = PH_AFIXED;
					lab_n   = FixedBytes;
				end else begin
					phase_n = PH_ALABEL;
					lab_n   = data_byte;
				end
			end
			PH_APTR: begin
				phase_n = PH_AFIXED;
				lab_n   = FixedBytes;
			end
			PH_ALEN: begin
				if (data_byte == 8'd0) begin
					phase_n = PH_AFIXED;
					lab_n   = FixedBytes;
				end else begin
					phase_n = PH_ALABEL;
					lab_n   = data_byte;
				end
			end
			PH_ALABEL: begin
				lab_n = lab_dec;
				if (lab_dec == 8'd0) phase_n = PH_ALEN;
			end
			PH_AFIXED: begin
				// lab counts 10..1: type, class, ttl (skipped), length
				if (lab_q >= 8'd9) rtype_n = {rtype_q[7:0], data_byte};
				else if (lab_q >= 8'd7) rclass_n = {rclass_q[7:0], data_byte};
				else if (lab_q <= 8'd2) rlen_n = {rlen_q[7:0], data_byte};
				lab_n = lab_dec;
				if (lab_dec == 8'd0) begin
					if (rtype_n == 16'd1 && rclass_n == 16'd1 && rlen_n == 16'd4) begin
						phase_n = PH_AADDR;
						lab_n   = AddrBytes;
						addr_n  = '0;
					end else if (rlen_n == 16'd0) begin
						ans_n   = ans_dec;
						phase_n = (ans_dec == 8'd0) ? PH_DONE : PH_AFIRST;
					end else begin
						phase_n = PH_ASKIP;
					end
				end
			end
			PH_AADDR: begin
				addr_n = {addr_q[23:0], data_byte};
				lab_n  = lab_dec;
				if (lab_dec == 8'd0) begin
					found_n = 1'b1;
					phase_n = PH_DONE;
				end
			end
			PH_ASKIP: begin
				rlen_n = rlen_q - 16'd1;
				if (rlen_n == 16'd0) begin
					ans_n   = ans_dec;
					phase_n = (ans_dec == 8'd0) ? PH_DONE : PH_AFIRST;
				end
			end
			default: phase_n = PH_DONE;
		endcase
	end

	// Status as seen after this byte has been taken.
	always_comb begin
		result.query_id      = id_n;
		result.response_code = code_n;
		result.ip_address    = '0;
		if (phase_n == PH_HEADER) begin
			result.status = dnsrp_pkg::ST_TRUNCATED;
		end else if (id_n >= IdLimit) begin
			result.status = dnsrp_pkg::ST_ID_RANGE;
		end else if (code_n != 4'd0) begin
			result.status = dnsrp_pkg::ST_SERVER_ERR;
		end else if (found_n) begin
			result.status     = dnsrp_pkg::ST_FOUND;
			result.ip_address = addr_n;
		end else if (phase_n == PH_DONE) begin
			result.status = dnsrp_pkg::ST_NO_ADDR;
		end else begin
			result.status = dnsrp_pkg::ST_TRUNCATED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			lab_q    <= '0;
			ans_q    <= '0;
			id_q     <= '0;
			code_q   <= '0;
			rtype_q  <= '0;
			rclass_q <= '0;
			rlen_q   <= '0;
			addr_q   <= '0;
			found_q  <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				phase_q  <= PH_HEADER;
				pos_q    <= '0;
				lab_q    <= '0;
				ans_q    <= '0;
				id_q     <= '0;
				code_q   <= '0;
				rtype_q  <= '0;
				rclass_q <= '0;
				rlen_q   <= '0;
				addr_q   <= '0;
				found_q  <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				lab_q    <= lab_n;
				ans_q    <= ans_n;
				id_q     <= id_n;
				code_q   <= code_n;
				rtype_q  <= rtype_n;
				rclass_q <= rclass_n;
				rlen_q   <= rlen_n;
				addr_q   <= addr_n;
				found_q  <= found_n;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/dns_response_parser.sv
// Top level of the DNS response parser: byte walker plus result register.
//
// Takes one payload byte per beat and can accept a byte every cycle. Each
// byte updates the parse state in the cycle it is accepted; the beat marked
// last produces one result beat (id, response code, IPv4 address, status)
// that is registered in the result register, and the parser is then ready for
// the next payload. Input is held off only while a result waits in the
// result register and the consumer is not taking it.
`timescale 1ns / 1ps
`default_nettype none
module dns_response_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      query_id,
	output logic [3:0]       response_code,
	output logic [31:0]      ip_address,
	output logic [2:0]       status
);

	dnsrp_pkg::res_t res;
	dnsrp_pkg::res_t res_q;
	logic            out_valid_q;
	logic            take;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	dnsrp_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_byte) res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign query_id      = res_q.query_id;
	assign response_code = res_q.response_code;
	assign ip_address    = res_q.ip_address;
	assign status        = res_q.status;

endmodule
`default_nettype wire

FILE: hdl/dnsrp_checker.sv
// Port-level checks for the DNS response parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dnsrp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] query_id,
	input wire logic [3:0]  response_code,
	input wire logic [31:0] ip_address,
	input wire logic [2:0]  status
);

	localparam logic [15:0] IdLimit = 16'(dnsrp_pkg::TABLE_ENTRIES);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(query_id)
			&& $stable(ip_address) && $stable(response_code))
		else $error("result beat changed while stalled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off with no pending result");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != dnsrp_pkg::ST_FOUND |-> ip_address == 32'd0)
		else $error("address given without found status");

	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dnsrp_pkg::ST_FOUND || status == dnsrp_pkg::ST_SERVER_ERR
			|| status == dnsrp_pkg::ST_NO_ADDR) |-> query_id < IdLimit)
		else $error("id out of range not reported");

	a_srv_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dnsrp_pkg::ST_FOUND || status == dnsrp_pkg::ST_NO_ADDR)
			|-> response_code == 4'd0)
		else $error("nonzero response code not reported");

endmodule

bind dns_response_parser dnsrp_checker u_dnsrp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.query_id      (query_id),
	.response_code (response_code),
	.ip_address    (ip_address),
	.status        (status)
);
`default_nettype wire

FILE: bench/dns_response_parser_test.sv
// Self-checking testbench for dns_response_parser: payload stream in, checked lookup replies out.
`timescale 1ns / 1ps
module dns_response_parser_test;

	localparam int HDR_LEN      = 12;
	localparam int FIXED_LEN    = 10;
	localparam int QTAIL_LEN    = 4;
	localparam int ADDR_LEN     = 4;
	localparam logic [7:0] PTR_MARK = 8'hc0;
	localparam logic [3:0] RCODE_MASK = 4'hf;
	localparam logic [15:0] TYPE_A   = 16'd1;
	localparam logic [15:0] CLASS_IN = 16'd1;
	localparam int RAND_BYTES   = 1800;
	localparam int MAX_ANSWERS  = 4;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	typedef enum logic [3:0] {
		W_HEADER, W_QLEN, W_QLABEL, W_QTAIL, W_AFIRST, W_APTR,
		W_ALEN, W_ALABEL, W_AFIXED, W_AADDR, W_ASKIP, W_DONE
	} walk_phase_t;

	typedef struct packed {
		logic [7:0]      b;
		logic            l;
		logic            chk;
		dnsrp_pkg::res_t want;
	} dir_row_t;

	// short header, id out of range with all-ones fields, server error
	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{8'hff, 1'b1, 1'b1, '{16'hff00, 4'h0, 32'h0, dnsrp_pkg::ST_TRUNCATED}},
		'{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b1, '{16'hffff, 4'hf, 32'h0, dnsrp_pkg::ST_ID_RANGE}},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h03, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hff, 1'b1, 1'b1, '{16'h0003, 4'h1, 32'h0, dnsrp_pkg::ST_SERVER_ERR}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] query_id;
	logic [3:0]  response_code;
	logic [31:0] ip_address;
	logic [2:0]  status;

	dns_response_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.query_id      (query_id),
		.response_code (response_code),
		.ip_address    (ip_address),
		.status        (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mirror of the parser state
	logic [15:0] pos_q;
	walk_phase_t wphase;
	logic [7:0]  lab_left;
	logic [7:0]  ans_left;
	logic [15:0] id_q;
	logic [3:0]  rcode_q;
	logic [15:0] rtype_q;
	logic [15:0] rclass_q;
	logic [15:0] rlen_q;
	logic [31:0] addr_q;
	logic        found_q;

	dnsrp_pkg::res_t pending_replies[$];
	int   errors = 0;
	int   replies_checked = 0;
	int   status_seen[5] = '{default: 0};
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   quiet_cycles = 0;

	task automatic clear_parser();
		pos_q = '0;
		wphase = W_HEADER;
		lab_left = '0;
		ans_left = '0;
		id_q = '0;
		rcode_q = '0;
		rtype_q = '0;
		rclass_q = '0;
		rlen_q = '0;
		addr_q = '0;
		found_q = 1'b0;
	endtask

	function automatic walk_phase_t after_answer(input logic [7:0] left);
		return (left == 8'd0) ? W_DONE : W_AFIRST;
	endfunction

	// advance the mirrored parser by one byte; a last byte yields the reply
	task automatic walk_byte(input logic [7:0] b, input logic is_last,
			output bit has_reply, output dnsrp_pkg::res_t reply);
		logic [7:0] idx;
		has_reply = 1'b0;
		reply = '0;
		case (wphase) inside
			W_HEADER: begin
				if (pos_q == 16'd0) id_q[15:8] = b;
				else if (pos_q == 16'd1) id_q[7:0] = b;
				else if (pos_q == 16'd3) rcode_q = b[3:0] & RCODE_MASK;
				else if (pos_q == 16'd7) ans_left = b;
				if (pos_q == 16'(HDR_LEN - 1)) wphase = W_QLEN;
			end
			W_QLEN: begin
				if (b == 8'd0) begin
					wphase = W_QTAIL;
					lab_left = 8'(QTAIL_LEN);
				end else begin
					wphase = W_QLABEL;
					lab_left = b;
				end
			end
			W_QLABEL: begin
				lab_left = lab_left - 8'd1;
				if (lab_left == 8'd0) wphase = W_QLEN;
			end
			W_QTAIL: begin
				lab_left = lab_left - 8'd1;
				if (lab_left == 8'd0) wphase = after_answer(ans_left);
			end
			W_AFIRST, W_ALEN: begin
				if (wphase == W_AFIRST && (b & PTR_MARK) != 8'd0) begin
					wphase = W_APTR;
				end else if (b == 8'd0) begin
					wphase = W_AFIXED;
					lab_left = 8'(FIXED_LEN);
				end else begin
					wphase = W_ALABEL;
					lab_left = b;
				end
			end
			W_APTR: begin
				wphase = W_AFIXED;
				lab_left = 8'(FIXED_LEN);
			end
			W_ALABEL: begin
				lab_left = lab_left - 8'd1;
				if (lab_left == 8'd0) wphase = W_ALEN;
			end
			W_AFIXED: begin
				idx = 8'(FIXED_LEN) - lab_left;
				if (idx < 8'd2) rtype_q = {rtype_q[7:0], b};
				else if (idx < 8'd4) rclass_q = {rclass_q[7:0], b};
				else if (idx >= 8'd8) rlen_q = {rlen_q[7:0], b};
				lab_left = lab_left - 8'd1;
				if (lab_left == 8'd0) begin
					if (rtype_q == TYPE_A && rclass_q == CLASS_IN
							&& rlen_q == 16'(ADDR_LEN)) begin
						wphase = W_AADDR;
						lab_left = 8'(ADDR_LEN);
						addr_q = '0;
					end else if (rlen_q == 16'd0) begin
						ans_left = ans_left - 8'd1;
						wphase = after_answer(ans_left);
					end else begin
						wphase = W_ASKIP;
					end
				end
			end
			W_AADDR: begin
				addr_q = {addr_q[23:0], b};
				lab_left = lab_left - 8'd1;
				if (lab_left == 8'd0) begin
					found_q = 1'b1;
					wphase = W_DONE;
				end
			end
			W_ASKIP: begin
				rlen_q = rlen_q - 16'd1;
				if (rlen_q == 16'd0) begin
					ans_left = ans_left - 8'd1;
					wphase = after_answer(ans_left);
				end
			end
			default: wphase = W_DONE;
		endcase
		if (pos_q != 16'hffff) pos_q = pos_q + 16'd1;

		if (is_last) begin
			has_reply = 1'b1;
			reply.query_id = id_q;
			reply.response_code = rcode_q;
			reply.ip_address = '0;
			if (pos_q < 16'(HDR_LEN)) reply.status = dnsrp_pkg::ST_TRUNCATED;
			else if ({16'd0, id_q} >= dnsrp_pkg::TABLE_ENTRIES)
				reply.status = dnsrp_pkg::ST_ID_RANGE;
			else if (rcode_q != 4'd0) reply.status = dnsrp_pkg::ST_SERVER_ERR;
			else if (found_q) begin
				reply.status = dnsrp_pkg::ST_FOUND;
				reply.ip_address = addr_q;
			end else if (wphase == W_DONE) reply.status = dnsrp_pkg::ST_NO_ADDR;
			else reply.status = dnsrp_pkg::ST_TRUNCATED;
			clear_parser();
		end
	endtask

	// present one beat, hold it until taken, then predict
	task automatic offer_byte(input logic [7:0] b, input logic is_last,
			output bit has_reply, output dnsrp_pkg::res_t reply);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		walk_byte(b, is_last, has_reply, reply);
	endtask

	// reply side: random stalls, scoreboard compare, watchdog
	always @(posedge clk) begin
		dnsrp_pkg::res_t want;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					$error("unexpected reply: query_id %h status %0d", query_id, status);
					errors++;
				end else begin
					want = pending_replies.pop_front();
					if (query_id !== want.query_id) begin
						$error("query_id: expected %h, got %h", want.query_id, query_id);
						errors++;
					end
					if (response_code !== want.response_code) begin
						$error("response_code: expected %h, got %h",
							want.response_code, response_code);
						errors++;
					end
					if (ip_address !== want.ip_address) begin
						$error("ip_address: expected %h, got %h", want.ip_address, ip_address);
						errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					replies_checked++;
					if (want.status <= dnsrp_pkg::ST_ID_RANGE) status_seen[want.status]++;
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		bit              has;
		dnsrp_pkg::res_t r;
		logic [7:0]      payload[$];
		logic [15:0]     rid;
		logic [15:0]     rtype;
		logic [15:0]     rclass;
		logic [15:0]     rlen;
		int              ancount;
		int              n_send;
		int              len;
		int              mode;
		int              bytes_rand;
		int              payloads;

		bytes_rand = 0;
		payloads = 0;
		clear_parser();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			offer_byte(DIRECTED[i].b, DIRECTED[i].l, has, r);
			if (DIRECTED[i].chk) pending_replies.push_back(DIRECTED[i].want);
			else if (has) pending_replies.push_back(r);
		end

		while (bytes_rand < RAND_BYTES) begin
			mode = (bytes_rand * 4) / RAND_BYTES;
			case (mode)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase

			payload.delete();
			if ($urandom_range(99) < 12) begin
				// noise
				repeat ($urandom_range(40, 1)) payload.push_back(8'($urandom));
			end else begin
				case ($urandom_range(19)) inside
					0, 1: rid = 16'($urandom);
					2, 3: rid = 16'(dnsrp_pkg::TABLE_ENTRIES);
					default: rid = 16'($urandom_range(dnsrp_pkg::TABLE_ENTRIES - 1));
				endcase
				payload.push_back(rid[15:8]);
				payload.push_back(rid[7:0]);
				payload.push_back(8'($urandom));
				if ($urandom_range(99) < 85) payload.push_back({4'($urandom), 4'h0});
				else payload.push_back(8'($urandom));
				repeat (3) payload.push_back(8'($urandom));
				ancount = ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom_range(255);
				payload.push_back(8'(ancount));
				repeat (4) payload.push_back(8'($urandom));

				// question name, terminator, type/class
				repeat ($urandom_range(3)) begin
					len = $urandom_range(5, 1);
					payload.push_back(8'(len));
					repeat (len) payload.push_back(8'($urandom));
				end
				payload.push_back(8'h00);
				repeat (QTAIL_LEN) payload.push_back(8'($urandom));

				for (int a = 0; a < ancount && a < MAX_ANSWERS; a++) begin
					case ($urandom_range(2))
						0: begin
							payload.push_back(8'($urandom_range(255, 64)));
							payload.push_back(8'($urandom));
						end
						1: payload.push_back(8'h00);
						default: begin
							// any length byte, the first one too, may carry the pointer bits: later ones still count
							for (int k = $urandom_range(3, 1); k > 0; k--) begin
								if (k != 0 && payload.size() > 0 && $urandom_range(9) == 0
										&& k < 3)
									len = $urandom_range(70, 64);
								else
									len = $urandom_range(4, 1);
								payload.push_back(8'(len));
								repeat (len) payload.push_back(8'($urandom));
							end
							payload.push_back(8'h00);
						end
					endcase
					rtype = ($urandom_range(99) < 70) ? TYPE_A : 16'($urandom);
					rclass = ($urandom_range(99) < 70) ? CLASS_IN : 16'($urandom);
					if (rtype == TYPE_A && rclass == CLASS_IN && $urandom_range(99) < 70)
						rlen = 16'(ADDR_LEN);
					else
						rlen = 16'($urandom_range(6));
					payload.push_back(rtype[15:8]);
					payload.push_back(rtype[7:0]);
					payload.push_back(rclass[15:8]);
					payload.push_back(rclass[7:0]);
					repeat (4) payload.push_back(8'($urandom));
					payload.push_back(rlen[15:8]);
					payload.push_back(rlen[7:0]);
					repeat (rlen) payload.push_back(8'($urandom));
				end
				repeat ($urandom_range(3)) payload.push_back(8'($urandom));
			end

			n_send = ($urandom_range(99) < 20) ? $urandom_range(payload.size(), 1)
				: payload.size();
			for (int i = 0; i < n_send; i++) begin
				offer_byte(payload[i], i == n_send - 1, has, r);
				if (has) pending_replies.push_back(r);
				bytes_rand++;
			end
			payloads++;
		end
		in_valid <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d random bytes in %0d payloads after %0d directed beats, %0d replies",
			bytes_rand, payloads, DIR_ROWS, replies_checked);
		$display("status mix: found %0d, srv err %0d, no addr %0d, truncated %0d, bad id %0d",
			status_seen[dnsrp_pkg::ST_FOUND], status_seen[dnsrp_pkg::ST_SERVER_ERR],
			status_seen[dnsrp_pkg::ST_NO_ADDR], status_seen[dnsrp_pkg::ST_TRUNCATED],
			status_seen[dnsrp_pkg::ST_ID_RANGE]);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
